// File: hw/rtl/rwct_pkg.sv
package rwct_pkg;

  // request codes
  localparam logic REQ_COLUMN = 1'b0;
  localparam logic REQ_ROW    = 1'b1;

  // configuration register indexes
  localparam logic [1:0] REG_TEX_SIZE_LOG2 = 2'd0;
  localparam logic [1:0] REG_CEILING_COLOR = 2'd1;
  localparam logic [1:0] REG_FLOOR_COLOR   = 2'd2;

  // pixel region codes
  localparam logic [1:0] REGION_CEILING   = 2'd0;
  localparam logic [1:0] REGION_WALL      = 2'd1;
  localparam logic [1:0] REGION_FLOOR     = 2'd2;
  localparam logic [1:0] REGION_UNTOUCHED = 2'd3;

  // signed width of the first wall row
  localparam int SPAN_W = 18;
  // line height saturation
  localparam logic [15:0] LH_MAX = 16'hFFFF;

  // controller to datapath commands
  typedef struct packed {
    logic start;
    logic lh_load;
    logic step_load;
    logic pos_load;
    logic row_fire;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic div_done;
  } stat_t;

  // texture size exponent clamped to 1..8
  function automatic logic [3:0] tex_shift(input logic [3:0] raw);
    logic [3:0] s;
    s = raw;
    if (raw < 4'd1) begin
      s = 4'd1;
    end else if (raw > 4'd8) begin
      s = 4'd8;
    end
    return s;
  endfunction

  // texel index mask for the clamped size
  function automatic logic [7:0] tex_mask(input logic [3:0] shift);
    logic [8:0] m;
    m = (9'd1 << shift) - 9'd1;
    return m[7:0];
  endfunction

endpackage

// File: hw/rtl/rwct_ctrl.sv
module rwct_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic           in_req_type,
  output logic           out_valid,
  input  logic           out_stall,
  output rwct_pkg::cmd_t cmd,
  input  rwct_pkg::stat_t stat
);
  import rwct_pkg::*;

  localparam logic [1:0] ST_IDLE     = 2'd0;
  localparam logic [1:0] ST_DIV_LH   = 2'd1;
  localparam logic [1:0] ST_DIV_STEP = 2'd2;
  localparam logic [1:0] ST_MUL_POS  = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;

  // input handshake and commands
  always_comb begin
    in_stall      = (state_r != ST_IDLE) | (out_valid_r & out_stall);
    accept        = in_valid & ~in_stall;
    cmd.start     = accept & (in_req_type == REQ_COLUMN);
    cmd.row_fire  = accept & (in_req_type == REQ_ROW);
    cmd.lh_load   = (state_r == ST_DIV_LH) & stat.div_done;
    cmd.step_load = (state_r == ST_DIV_STEP) & stat.div_done;
    cmd.pos_load  = (state_r == ST_MUL_POS);
  end

  // column setup sequence
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.start) state_nxt = ST_DIV_LH;
      end
      ST_DIV_LH: begin
        if (stat.div_done) state_nxt = ST_DIV_STEP;
      end
      ST_DIV_STEP: begin
        if (stat.div_done) state_nxt = ST_MUL_POS;
      end
      ST_MUL_POS: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // output register occupancy
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.row_fire) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// File: hw/rtl/rwct_datapath.sv
module rwct_datapath #(
  parameter int SCREEN_HEIGHT = 512
) (
  input  logic               clk,
  input  logic               rst_n,
  input  rwct_pkg::cmd_t     cmd,
  output rwct_pkg::stat_t    stat,
  input  logic [3:0]         tex_size_log2,
  input  logic [31:0]        ceiling_color,
  input  logic [31:0]        floor_color,
  input  logic [9:0]         in_column,
  input  logic [31:0]        in_wall_dist,
  input  logic [1:0]         in_face,
  input  logic signed [20:0] in_ray_dir_x,
  input  logic signed [20:0] in_ray_dir_y,
  input  logic [31:0]        in_eye_x,
  input  logic [31:0]        in_eye_y,
  output logic [9:0]         out_column,
  output logic [8:0]         out_row,
  output logic [1:0]         out_region,
  output logic [1:0]         out_texture_id,
  output logic [7:0]         out_tex_col,
  output logic [7:0]         out_tex_row,
  output logic [31:0]        out_fill_color,
  output logic               out_last_row
);
  import rwct_pkg::*;

  localparam int ROW_W     = $clog2(SCREEN_HEIGHT);
  localparam int ROW_EXT_W = (ROW_W > 9) ? ROW_W : 9;
  localparam int HALF_H    = SCREEN_HEIGHT / 2;
  localparam int NUM_W     = ($clog2(SCREEN_HEIGHT) + 17 > 25) ?
                             ($clog2(SCREEN_HEIGHT) + 17) : 25;
  localparam int CNT_W     = $clog2(NUM_W + 1);
  localparam logic [NUM_W-1:0] LH_NUM = NUM_W'(SCREEN_HEIGHT) << 16;

  // column latches
  logic [9:0]              col_latch_r;
  logic [1:0]              face_latch_r;
  logic [31:0]             dist_r;
  logic [31:0]             prod_r;
  logic [15:0]             eye_lo_r;
  logic                    mirror_r;
  logic [15:0]             lh_r;
  logic signed [SPAN_W-1:0] span_top_r;
  logic [ROW_W-1:0]        span_bottom_r;
  logic [7:0]              texel_col_r;
  logic [31:0]             texel_pos_r, texel_pos_nxt;
  logic [31:0]             texel_step_r;
  logic [ROW_W-1:0]        row_cnt_r, row_cnt_nxt;

  // divider
  logic [31:0]             rem_r, rem_nxt;
  logic [NUM_W-1:0]        quo_r, quo_nxt;
  logic [31:0]             divisor_r;
  logic [CNT_W-1:0]        div_cnt_r;
  logic [32:0]             div_shift, div_diff;

  logic [3:0]              shift;
  logic [7:0]              mask;
  logic [31:0]             dir_ext;
  logic [31:0]             prod_lo;
  logic [15:0]             frac;
  logic [15:0]             col16;
  logic [7:0]              col_sel;
  logic [15:0]             lh_val;
  logic [16:0]             bot_sum;
  logic [15:0]             pos_term;
  logic [NUM_W-1:0]        step_num;
  logic signed [SPAN_W-1:0] row_s;
  logic [ROW_W:0]          row_inc;
  logic [ROW_EXT_W-1:0]    row_ext;
  logic [1:0]              out_region_nxt;

  assign shift = tex_shift(tex_size_log2);
  assign mask  = tex_mask(shift);

  // hit coordinate product, low word only
  always_comb begin
    if (in_face <= 2'd1) begin
      dir_ext = {{11{in_ray_dir_y[20]}}, in_ray_dir_y};
    end else begin
      dir_ext = {{11{in_ray_dir_x[20]}}, in_ray_dir_x};
    end
    prod_lo = in_wall_dist * dir_ext;
  end

  // texel column from the hit fraction
  always_comb begin
    frac    = eye_lo_r + prod_r[31:16];
    col16   = frac >> (5'd16 - {1'b0, shift});
    col_sel = mirror_r ? (~col16[7:0] & mask) : col16[7:0];
  end

  // line height, span limits, step dividend and start position term
  always_comb begin
    if (dist_r == 32'd0) begin
      lh_val = 16'd0;
    end else if (quo_r > NUM_W'(LH_MAX)) begin
      lh_val = LH_MAX;
    end else begin
      lh_val = quo_r[15:0];
    end
    bot_sum  = 17'(lh_val[15:1]) + 17'(HALF_H);
    step_num = NUM_W'(1) << (5'd16 + {1'b0, shift});
    pos_term = (span_top_r < 0) ? (16'(lh_r[15:1]) - 16'(HALF_H)) : 16'd0;
  end

  // restoring divider, one quotient bit per cycle
  always_comb begin
    div_shift = {rem_r, quo_r[NUM_W-1]};
    div_diff  = div_shift - {1'b0, divisor_r};
    if (!div_diff[32]) begin
      rem_nxt = div_diff[31:0];
      quo_nxt = {quo_r[NUM_W-2:0], 1'b1};
    end else begin
      rem_nxt = div_shift[31:0];
      quo_nxt = {quo_r[NUM_W-2:0], 1'b0};
    end
  end

  assign stat.div_done = (div_cnt_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_cnt_r <= '0;
    end else if (cmd.start || cmd.lh_load) begin
      div_cnt_r <= CNT_W'(NUM_W);
    end else if (div_cnt_r != '0) begin
      div_cnt_r <= div_cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rem_r     <= '0;
      quo_r     <= LH_NUM;
      divisor_r <= in_wall_dist;
    end else if (cmd.lh_load) begin
      rem_r     <= '0;
      quo_r     <= step_num;
      divisor_r <= {16'd0, lh_val};
    end else if (div_cnt_r != '0) begin
      rem_r     <= rem_nxt;
      quo_r     <= quo_nxt;
    end
  end

  // row classification and next row state
  always_comb begin
    row_s          = SPAN_W'(row_cnt_r);
    row_ext        = ROW_EXT_W'(row_cnt_r);
    row_inc        = {1'b0, row_cnt_r} + (ROW_W + 1)'(1);
    row_cnt_nxt    = (row_inc >= (ROW_W + 1)'(SCREEN_HEIGHT)) ? '0 : row_inc[ROW_W-1:0];
    texel_pos_nxt  = texel_pos_r;
    out_region_nxt = REGION_FLOOR;
    priority if (row_s < span_top_r) begin
      out_region_nxt = REGION_CEILING;
    end else if (row_cnt_r < span_bottom_r) begin
      out_region_nxt = REGION_WALL;
      texel_pos_nxt  = texel_pos_r + texel_step_r;
    end else if (row_cnt_r == span_bottom_r) begin
      out_region_nxt = REGION_UNTOUCHED;
    end else begin
      out_region_nxt = REGION_FLOOR;
    end
  end

  // column state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_latch_r   <= '0;
      face_latch_r  <= '0;
      span_top_r    <= '0;
      span_bottom_r <= '0;
      texel_col_r   <= '0;
      texel_pos_r   <= '0;
      texel_step_r  <= '0;
      row_cnt_r     <= '0;
      lh_r          <= '0;
    end else begin
      if (cmd.start) begin
        col_latch_r  <= in_column;
        face_latch_r <= in_face;
        row_cnt_r    <= '0;
      end else if (cmd.row_fire) begin
        row_cnt_r    <= row_cnt_nxt;
        texel_pos_r  <= texel_pos_nxt;
      end
      if (cmd.lh_load) begin
        lh_r          <= lh_val;
        texel_col_r   <= col_sel;
        span_top_r    <= SPAN_W'(HALF_H) - SPAN_W'(lh_val[15:1]);
        span_bottom_r <= (bot_sum >= 17'(SCREEN_HEIGHT)) ?
                         ROW_W'(SCREEN_HEIGHT - 1) : bot_sum[ROW_W-1:0];
      end
      if (cmd.step_load) begin
        texel_step_r <= (lh_r == 16'd0) ? 32'd0 : 32'(quo_r);
      end
      if (cmd.pos_load) begin
        texel_pos_r <= 32'(pos_term * texel_step_r);
      end
    end
  end

  // per-column operands captured at the start transaction
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      dist_r   <= in_wall_dist;
      prod_r   <= prod_lo;
      eye_lo_r <= (in_face <= 2'd1) ? in_eye_y[15:0] : in_eye_x[15:0];
      mirror_r <= ((in_face == 2'd0) && !in_ray_dir_x[20] && (in_ray_dir_x != '0)) ||
                  ((in_face == 2'd1) && in_ray_dir_y[20]);
    end
  end

  // pixel output register
  always_ff @(posedge clk) begin
    if (cmd.row_fire) begin
      out_column     <= col_latch_r;
      out_row        <= row_ext[8:0];
      out_region     <= out_region_nxt;
      out_texture_id <= (out_region_nxt == REGION_WALL) ? face_latch_r : 2'd0;
      out_tex_col    <= (out_region_nxt == REGION_WALL) ? texel_col_r : 8'd0;
      out_tex_row    <= (out_region_nxt == REGION_WALL) ? (texel_pos_r[23:16] & mask) : 8'd0;
      out_last_row   <= (row_cnt_r == ROW_W'(SCREEN_HEIGHT - 1));
      unique case (out_region_nxt)
        REGION_CEILING: out_fill_color <= ceiling_color;
        REGION_FLOOR:   out_fill_color <= floor_color;
        default:        out_fill_color <= 32'd0;
      endcase
    end
  end

endmodule

// File: hw/rtl/raycast_wall_column_texturer.sv
// Textured wall column generator for a raycaster. A column-start transaction
// (req_type 0) carries the hit geometry of one screen column; the block then
// sets the column up with the shared bit-serial divider, whose quotient is
// max(clog2(SCREEN_HEIGHT)+17, 25) bits wide (26 at the default height) and
// which runs once for the line height and once for the texel row step. During
// setup the input is stalled. Each row transaction (req_type 1) then yields one
// pixel a cycle through a registered output, unless out_stall holds that output:
// ceiling fill, textured wall texel, floor fill, or untouched at the span end.
// The row counter wraps after the bottom row. Configuration is written with cfg_wr_en;
// the user must write it only while no transaction is in flight, as the block does not enforce this.
module raycast_wall_column_texturer #(
  parameter int SCREEN_HEIGHT = 512
) (
  input  logic               clk,
  input  logic               rst_n,
  // configuration
  input  logic               cfg_wr_en,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_wdata,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_req_type,
  input  logic [9:0]         in_column,
  input  logic [31:0]        in_wall_dist,
  input  logic [1:0]         in_face,
  input  logic signed [20:0] in_ray_dir_x,
  input  logic signed [20:0] in_ray_dir_y,
  input  logic [31:0]        in_eye_x,
  input  logic [31:0]        in_eye_y,
  // pixel channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [9:0]         out_column,
  output logic [8:0]         out_row,
  output logic [1:0]         out_region,
  output logic [1:0]         out_texture_id,
  output logic [7:0]         out_tex_col,
  output logic [7:0]         out_tex_row,
  output logic [31:0]        out_fill_color,
  output logic               out_last_row
);
  import rwct_pkg::*;

  logic [3:0]  tex_size_log2_r;
  logic [31:0] ceiling_color_r;
  logic [31:0] floor_color_r;
  cmd_t        cmd;
  stat_t       stat;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tex_size_log2_r <= 4'd6;
      ceiling_color_r <= '0;
      floor_color_r   <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_TEX_SIZE_LOG2: tex_size_log2_r <= cfg_wdata[3:0];
        REG_CEILING_COLOR: ceiling_color_r <= cfg_wdata;
        REG_FLOOR_COLOR:   floor_color_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  rwct_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_req_type (in_req_type),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .cmd         (cmd),
    .stat        (stat)
  );

  rwct_datapath #(
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .tex_size_log2  (tex_size_log2_r),
    .ceiling_color  (ceiling_color_r),
    .floor_color    (floor_color_r),
    .in_column      (in_column),
    .in_wall_dist   (in_wall_dist),
    .in_face        (in_face),
    .in_ray_dir_x   (in_ray_dir_x),
    .in_ray_dir_y   (in_ray_dir_y),
    .in_eye_x       (in_eye_x),
    .in_eye_y       (in_eye_y),
    .out_column     (out_column),
    .out_row        (out_row),
    .out_region     (out_region),
    .out_texture_id (out_texture_id),
    .out_tex_col    (out_tex_col),
    .out_tex_row    (out_tex_row),
    .out_fill_color (out_fill_color),
    .out_last_row   (out_last_row)
  );

endmodule

// File: sim/tb_raycast_wall_column_texturer.sv
module tb_raycast_wall_column_texturer;
  timeunit 1ns;
  timeprecision 1ps;

  import rwct_pkg::*;

  localparam int SCREEN_H = 512;
  // bound on column setup at this height, plus margin
  localparam int SETUP_CYCLES = 150;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam logic [1:0] REG_UNMAPPED = 2'd3;

  typedef struct {
    logic               req_type;
    logic [9:0]         column;
    logic [31:0]        wall_dist;
    logic [1:0]         face;
    logic signed [20:0] dir_x;
    logic signed [20:0] dir_y;
    logic [31:0]        eye_x;
    logic [31:0]        eye_y;
  } ray_req_t;

  typedef struct packed {
    logic [9:0]  column;
    logic [8:0]  row;
    logic [1:0]  region;
    logic [1:0]  texture_id;
    logic [7:0]  tex_col;
    logic [7:0]  tex_row;
    logic [31:0] fill_color;
    logic        last_row;
  } pixel_t;

  logic               clk;
  logic               rst_n;
  logic               cfg_wr_en;
  logic [1:0]         cfg_index;
  logic [31:0]        cfg_wdata;
  logic               in_valid;
  logic               in_stall;
  logic               in_req_type;
  logic [9:0]         in_column;
  logic [31:0]        in_wall_dist;
  logic [1:0]         in_face;
  logic signed [20:0] in_ray_dir_x;
  logic signed [20:0] in_ray_dir_y;
  logic [31:0]        in_eye_x;
  logic [31:0]        in_eye_y;
  logic               out_valid;
  logic               out_stall;
  logic [9:0]         out_column;
  logic [8:0]         out_row;
  logic [1:0]         out_region;
  logic [1:0]         out_texture_id;
  logic [7:0]         out_tex_col;
  logic [7:0]         out_tex_row;
  logic [31:0]        out_fill_color;
  logic               out_last_row;

  // register copies
  logic [3:0]  tex_log2_cfg;
  logic [31:0] ceil_rgba;
  logic [31:0] floor_rgba;

  // column state of the predictor
  logic [9:0]  lat_column;
  logic [1:0]  lat_face;
  int          wall_top;
  logic [9:0]  wall_end;
  logic [7:0]  tx_column;
  logic [31:0] tx_pos;
  logic [31:0] tx_step;
  logic [9:0]  scan_row;

  pixel_t expected_pixels[$];
  bit     gaps_enabled = 1'b1;
  int     error_count = 0;
  int     columns_started = 0;
  int     pixels_checked = 0;
  int     wall_pixels = 0;
  int     idle_cycles = 0;

  raycast_wall_column_texturer #(
    .SCREEN_HEIGHT(SCREEN_H)
  ) u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_req_type    (in_req_type),
    .in_column      (in_column),
    .in_wall_dist   (in_wall_dist),
    .in_face        (in_face),
    .in_ray_dir_x   (in_ray_dir_x),
    .in_ray_dir_y   (in_ray_dir_y),
    .in_eye_x       (in_eye_x),
    .in_eye_y       (in_eye_y),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_column     (out_column),
    .out_row        (out_row),
    .out_region     (out_region),
    .out_texture_id (out_texture_id),
    .out_tex_col    (out_tex_col),
    .out_tex_row    (out_tex_row),
    .out_fill_color (out_fill_color),
    .out_last_row   (out_last_row)
  );

  // 100 MHz clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // texture size exponent, out-of-range codes pinned to 1..8
  function automatic int unsigned size_log2_clamped();
    if (tex_log2_cfg < 4'd1) begin
      return 1;
    end else if (tex_log2_cfg > 4'd8) begin
      return 8;
    end
    return tex_log2_cfg;
  endfunction

  // wall span, texel column and texel row stepping for a new column
  function automatic void latch_column_geometry(ray_req_t r);
    logic [63:0]        quot;
    logic [31:0]        lh;
    logic [31:0]        bottom;
    logic [31:0]        vis_top;
    logic [31:0]        size;
    logic [31:0]        col;
    logic [31:0]        hit;
    logic [31:0]        eye;
    logic [31:0]        frac_scaled;
    logic signed [63:0] dist_s;
    logic signed [63:0] dir_s;
    logic signed [63:0] prod;
    int                 top;
    size = 32'd1 << size_log2_clamped();
    lh = 32'd0;
    if (r.wall_dist != 32'd0) begin
      quot = (64'(SCREEN_H) << 16) / {32'd0, r.wall_dist};
      lh = (quot > 64'd65535) ? 32'd65535 : quot[31:0];
    end
    top = SCREEN_H / 2 - int'(lh >> 1);
    bottom = (lh >> 1) + SCREEN_H / 2;
    if (bottom >= SCREEN_H) begin
      bottom = SCREEN_H - 1;
    end
    tx_step = (lh != 32'd0) ? (size << 16) / lh : 32'd0;
    vis_top = (top < 0) ? 32'd0 : 32'(top);
    tx_pos = (vis_top - SCREEN_H / 2 + (lh >> 1)) * tx_step;
    // hit coordinate along the wall, only its fraction matters
    dist_s = {32'd0, r.wall_dist};
    if (r.face <= 2'd1) begin
      dir_s = r.dir_y;
      eye = r.eye_y;
    end else begin
      dir_s = r.dir_x;
      eye = r.eye_x;
    end
    prod = dist_s * dir_s;
    hit = eye + prod[47:16];
    frac_scaled = {16'd0, hit[15:0]} * size;
    col = frac_scaled >> 16;
    if ((r.face == 2'd0 && r.dir_x > 0) || (r.face == 2'd1 && r.dir_y < 0)) begin
      col = size - col - 32'd1;
    end
    lat_column = r.column;
    lat_face = r.face;
    wall_top = top;
    wall_end = bottom[9:0];
    tx_column = col[7:0];
    scan_row = 10'd0;
    columns_started++;
  endfunction

  // pixel produced by one row transaction
  function automatic pixel_t next_pixel();
    pixel_t     p;
    int         row_s;
    logic [7:0] mask;
    p = '0;
    row_s = int'(scan_row);
    mask = 8'((32'd1 << size_log2_clamped()) - 32'd1);
    p.column = lat_column;
    p.row = scan_row[8:0];
    if (row_s < wall_top) begin
      p.region = REGION_CEILING;
      p.fill_color = ceil_rgba;
    end else if (scan_row < wall_end) begin
      p.region = REGION_WALL;
      p.texture_id = lat_face;
      p.tex_col = tx_column;
      p.tex_row = tx_pos[23:16] & mask;
      tx_pos = tx_pos + tx_step;
      wall_pixels++;
    end else if (scan_row == wall_end) begin
      p.region = REGION_UNTOUCHED;
    end else begin
      p.region = REGION_FLOOR;
      p.fill_color = floor_rgba;
    end
    p.last_row = (scan_row == SCREEN_H - 1);
    scan_row = (scan_row + 1 >= SCREEN_H) ? 10'd0 : scan_row + 10'd1;
    return p;
  endfunction

  // sender gap, mostly short with a few long ones
  function automatic int pick_gap();
    int pick;
    pick = $urandom_range(99);
    if (pick < 55) begin
      return 0;
    end else if (pick < 85) begin
      return $urandom_range(2, 1);
    end else if (pick < 97) begin
      return $urandom_range(8, 3);
    end
    return $urandom_range(50, 20);
  endfunction

  function automatic ray_req_t make_ray(logic kind, logic [9:0] column, logic [31:0] wdist,
                                        logic [1:0] face, logic signed [20:0] dx,
                                        logic signed [20:0] dy, logic [31:0] ex,
                                        logic [31:0] ey);
    ray_req_t r;
    r.req_type = kind;
    r.column = column;
    r.wall_dist = wdist;
    r.face = face;
    r.dir_x = dx;
    r.dir_y = dy;
    r.eye_x = ex;
    r.eye_y = ey;
    return r;
  endfunction

  // random direction component: full range, small, or zero
  function automatic logic signed [20:0] random_dir();
    int pick;
    pick = $urandom_range(99);
    if (pick < 50) begin
      return 21'($urandom);
    end else if (pick < 90) begin
      return 21'(int'($urandom_range(131072)) - 65536);
    end
    return 21'sd0;
  endfunction

  // random geometry, distances biased toward spans that reach the top rows
  function automatic ray_req_t random_ray(logic kind);
    ray_req_t r;
    int       pick;
    r.req_type = kind;
    r.column = 10'($urandom);
    pick = $urandom_range(99);
    if (pick < 10) begin
      r.wall_dist = 32'd0;
    end else if (pick < 20) begin
      r.wall_dist = $urandom;
    end else if (pick < 65) begin
      r.wall_dist = $urandom_range(32'h0001_0000, 32'd1);
    end else if (pick < 90) begin
      r.wall_dist = $urandom_range(32'h0001_4000, 32'h0001_0000);
    end else begin
      r.wall_dist = $urandom_range(32'h0020_0000, 32'h0001_4000);
    end
    r.face = 2'($urandom);
    r.dir_x = random_dir();
    r.dir_y = random_dir();
    r.eye_x = $urandom;
    r.eye_y = $urandom;
    return r;
  endfunction

  // drive one transaction and update the predictor once it is taken
  task automatic send_request(ray_req_t r);
    int gap;
    gap = gaps_enabled ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_req_type = r.req_type;
    in_column = r.column;
    in_wall_dist = r.wall_dist;
    in_face = r.face;
    in_ray_dir_x = r.dir_x;
    in_ray_dir_y = r.dir_y;
    in_eye_x = r.eye_x;
    in_eye_y = r.eye_y;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    if (r.req_type == REQ_COLUMN) begin
      latch_column_geometry(r);
    end else begin
      expected_pixels.push_back(next_pixel());
    end
  endtask

  task automatic send_rows(int count);
    repeat (count) send_request(random_ray(REQ_ROW));
  endtask

  // drain all pixels, then let any column setup finish
  task automatic settle_block();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (SETUP_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(logic [1:0] index, logic [31:0] data);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_index = index;
    cfg_wdata = data;
    case (index)
      REG_TEX_SIZE_LOG2: begin
        tex_log2_cfg = data[3:0];
      end
      REG_CEILING_COLOR: begin
        ceil_rgba = data;
      end
      REG_FLOOR_COLOR: begin
        floor_rgba = data;
      end
      default: begin
      end
    endcase
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  task automatic apply_settings(logic [3:0] size_log2, logic [31:0] ceil_c,
                                logic [31:0] floor_c);
    settle_block();
    write_register(REG_TEX_SIZE_LOG2, {28'd0, size_log2});
    write_register(REG_CEILING_COLOR, ceil_c);
    write_register(REG_FLOOR_COLOR, floor_c);
  endtask

  // column starts each followed by a run of rows, some left empty
  task automatic run_random_traffic(int n_items);
    int sent;
    int pick;
    int rows;
    sent = 0;
    while (sent < n_items) begin
      gaps_enabled = ($urandom_range(99) >= 20);
      send_request(random_ray(REQ_COLUMN));
      sent++;
      pick = $urandom_range(99);
      if (pick < 5) begin
        rows = 0;
      end else if (pick < 75) begin
        rows = $urandom_range(12, 1);
      end else begin
        rows = $urandom_range(60, 13);
      end
      send_rows(rows);
      sent += rows;
    end
    gaps_enabled = 1'b1;
  endtask

  // rows with no column start run on the reset span
  task automatic test_rows_after_reset();
    send_rows(4);
  endtask

  // hand-picked geometry: zero and tiny distances, saturation, mirroring per face
  task automatic test_column_geometry();
    apply_settings(4'd8, 32'hFFFF_FFFF, 32'h00FF_00FF);
    send_request(make_ray(REQ_COLUMN, 10'd1023, 32'd0, 2'd3, 21'h10_0000, 21'h0F_FFFF,
                          32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_rows(2);
    send_request(make_ray(REQ_COLUMN, 10'd0, 32'd1, 2'd0, 21'sd1, 21'h10_0000,
                          32'd0, 32'd0));
    send_rows(3);
    send_request(make_ray(REQ_COLUMN, 10'd512, 32'h0001_0000, 2'd0, 21'h1F_FFFB,
                          21'h01_2345, 32'h0000_1111, 32'h0003_8000));
    send_rows(2);
    send_request(make_ray(REQ_COLUMN, 10'd341, 32'hFFFF_FFFF, 2'd1, 21'sd0, 21'h1F_FFFF,
                          32'h0, 32'h1234_5678));
    send_rows(1);
    send_request(make_ray(REQ_COLUMN, 10'd682, 32'h0000_8000, 2'd1, 21'h00_4000,
                          21'h0F_FFFF, 32'h0, 32'h0000_FFFF));
    send_rows(2);
    send_request(make_ray(REQ_COLUMN, 10'd85, 32'h0200_0000, 2'd2, 21'h0F_FFFF, 21'sd0,
                          32'hFFFF_0000, 32'h0));
    send_rows(1);
    send_request(make_ray(REQ_COLUMN, 10'd938, 32'h0000_C000, 2'd3, 21'h1F_0000,
                          21'h00_0001, 32'h8000_8000, 32'h0));
    send_rows(2);
  endtask

  // smallest and largest texture
  task automatic test_texture_size_extremes();
    apply_settings(4'd1, $urandom, $urandom);
    run_random_traffic(20);
    apply_settings(4'd8, 32'h0000_0000, 32'hFFFF_FFFF);
    run_random_traffic(20);
  endtask

  // size codes below and above the legal range
  task automatic test_texture_size_clamp();
    apply_settings(4'd0, $urandom, $urandom);
    run_random_traffic(20);
    apply_settings(4'd15, $urandom, $urandom);
    run_random_traffic(20);
  endtask

  // a write to the spare index must change nothing
  task automatic test_unmapped_register();
    settle_block();
    write_register(REG_UNMAPPED, $urandom);
    run_random_traffic(15);
  endtask

  // one column scanned past the bottom row so the counter wraps
  task automatic test_row_wrap();
    ray_req_t r;
    apply_settings(4'($urandom_range(7, 2)), $urandom, $urandom);
    r = random_ray(REQ_COLUMN);
    r.wall_dist = $urandom_range(32'h0001_8000, 32'h0000_8000);
    send_request(r);
    send_rows(SCREEN_H + 20);
  endtask

  task automatic test_random_traffic();
    apply_settings(4'($urandom_range(15)), $urandom, $urandom);
    run_random_traffic(40);
  endtask

  function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      error_count++;
    end
  endfunction

  // pixel checker
  always @(posedge clk) begin
    pixel_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_pixels.size() == 0) begin
        $display("%0t: pixel with no transaction waiting, column %0h row %0h region %0h",
                 $time, out_column, out_row, out_region);
        error_count++;
      end else begin
        want = expected_pixels.pop_front();
        check_field("column", 32'(want.column), 32'(out_column));
        check_field("row", 32'(want.row), 32'(out_row));
        check_field("region", 32'(want.region), 32'(out_region));
        check_field("texture_id", 32'(want.texture_id), 32'(out_texture_id));
        check_field("tex_col", 32'(want.tex_col), 32'(out_tex_col));
        check_field("tex_row", 32'(want.tex_row), 32'(out_tex_row));
        check_field("fill_color", want.fill_color, out_fill_color);
        check_field("last_row", 32'(want.last_row), 32'(out_last_row));
        pixels_checked++;
      end
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
      $display("raycast_wall_column_texturer test failed");
      $finish;
    end
  end

  // receiver stall pattern: short gaps, a few long ones, long free stretches
  initial begin
    int run;
    int len;
    int pick;
    out_stall = 1'b0;
    forever begin
      run = ($urandom_range(99) < 85) ? $urandom_range(8) : $urandom_range(200, 50);
      pick = $urandom_range(99);
      if (pick < 80) begin
        len = $urandom_range(2, 1);
      end else if (pick < 95) begin
        len = $urandom_range(8, 3);
      end else begin
        len = $urandom_range(60, 20);
      end
      repeat (run) @(negedge clk);
      @(negedge clk);
      out_stall = 1'b1;
      repeat (len - 1) @(negedge clk);
      @(negedge clk);
      out_stall = 1'b0;
    end
  end

  // main sequence
  initial begin
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = REG_TEX_SIZE_LOG2;
    cfg_wdata = 32'd0;
    in_valid = 1'b0;
    in_req_type = REQ_ROW;
    in_column = 10'd0;
    in_wall_dist = 32'd0;
    in_face = 2'd0;
    in_ray_dir_x = 21'sd0;
    in_ray_dir_y = 21'sd0;
    in_eye_x = 32'd0;
    in_eye_y = 32'd0;
    tex_log2_cfg = 4'd6;
    ceil_rgba = 32'd0;
    floor_rgba = 32'd0;
    lat_column = 10'd0;
    lat_face = 2'd0;
    wall_top = 0;
    wall_end = 10'd0;
    tx_column = 8'd0;
    tx_pos = 32'd0;
    tx_step = 32'd0;
    scan_row = 10'd0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_rows_after_reset();
    test_column_geometry();
    test_texture_size_extremes();
    test_texture_size_clamp();
    test_unmapped_register();
    test_row_wrap();
    test_random_traffic();
    settle_block();

    $display("covered %0d column setups and %0d pixels, %0d of them wall texels,",
             columns_started, pixels_checked, wall_pixels);
    $display("with texture sizes 2 to 256, out-of-range size codes and a full row wrap");
    if (error_count == 0) begin
      $display("raycast_wall_column_texturer test passed");
    end else begin
      $display("raycast_wall_column_texturer test failed");
    end
    $finish;
  end

endmodule
